/* hw/rtl/motor_axis_calibrate_and_drive_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the motor axis controller
// ---------------------------------------------------------------------------
`ifndef MOTOR_AXIS_CALIBRATE_AND_DRIVE_MACROS_SVH
`define MOTOR_AXIS_CALIBRATE_AND_DRIVE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MAX_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define MAX_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define MAX_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define MAX_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

/* hw/rtl/max_pkg.sv */
// ---------------------------------------------------------------------------
// Motor axis controller package
// Shared types, codes and constants for controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none
package max_pkg;
    localparam int PosBits  = 16;
    localparam int TimeBits = 32;
    localparam int DivSteps = 2 * PosBits + 2;
    localparam int CntBits  = $clog2(DivSteps + 1);

    localparam logic [TimeBits-1:0] WaitDirMs  = TimeBits'(500);
    localparam logic [TimeBits-1:0] TimeoutMs  = TimeBits'(6000);
    localparam logic signed [7:0]   CalSpeed   = 8'sd50;
    localparam logic signed [7:0]   LinSpeed   = 8'sd40;
    localparam logic [PosBits-1:0]  HomePos    = PosBits'(500);
    localparam logic [PosBits-1:0]  BwdPreset  = PosBits'(48000);
    localparam logic [PosBits-1:0]  MaxPreset  = PosBits'(65000);

    typedef enum logic [3:0] {
        OP_STEP = 4'd0, OP_LIMIT = 4'd1, OP_TARGET = 4'd2, OP_ROTATE = 4'd3,
        OP_STOP = 4'd4, OP_RESUME = 4'd5, OP_CALIB = 4'd6, OP_SUSPEND = 4'd7,
        OP_PID = 4'd8, OP_LINEAR = 4'd9
    } t_op;

    typedef enum logic [2:0] {
        SRC_SUSP = 3'd0, SRC_CAL = 3'd1, SRC_PIDS = 3'd2, SRC_LIN = 3'd3, SRC_CMD = 3'd4
    } t_src;

    localparam logic [3:0] StgNone = 4'd0, StgReq = 4'd1, StgBwdDir = 4'd2,
        StgBwdVer = 4'd3, StgBwdLim = 4'd4, StgBwdHit = 4'd5, StgStop = 4'd6,
        StgFwdDir = 4'd7, StgFwdVer = 4'd8, StgFwdLim = 4'd9, StgFwdHit = 4'd10,
        StgCentre = 4'd11, StgDone = 4'd12, StgAbort = 4'd13;

    localparam logic [1:0] FaultNone = 2'd0, FaultDir = 2'd1, FaultTime = 2'd2;

    localparam logic [1:0] RegMinT = 2'd0, RegMaxT = 2'd1, RegGap = 2'd2, RegHit = 2'd3;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} t_state;

    // controller to datapath
    typedef struct packed {
        logic exec;      // apply the held item (all ops but scaled target)
        logic div_start; // load the divider
        logic div_step;  // one restoring step
        logic div_done;  // write scaled target
        logic out_load;  // capture result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_target;
        logic div_last;
    } t_sts;
endpackage
`default_nettype wire

/* hw/rtl/max_ctrl.sv */
// ---------------------------------------------------------------------------
// Motor axis controller sequencer
// Steps each transaction through execute, optional division and output.
// ---------------------------------------------------------------------------
`default_nettype none
`include "motor_axis_calibrate_and_drive_macros.svh"
module max_ctrl
    import max_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_fire,
    input  wire  i_out_fire,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready,
    output logic o_out_valid
);
    t_state r_state, n_state;

    // advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_fire) n_state = ST_DIV;
            ST_DIV: begin
                if (!i_sts.is_target || i_sts.div_last) n_state = ST_OUT;
            end
            ST_OUT: if (i_out_fire) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.div_start = i_in_fire;
            end
            ST_DIV: begin
                if (!i_sts.is_target) begin
                    o_cmd.exec = 1'b1;
                    o_cmd.out_load = 1'b1;
                end else if (i_sts.div_last) begin
                    o_cmd.div_done = 1'b1;
                    o_cmd.out_load = 1'b1;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_OUT: o_out_valid = 1'b1;
            default: ;
        endcase
    end

    `MAX_ASSERT_NXT(a_in_leaves_idle, i_clk, i_rst_n, i_in_fire, r_state == ST_DIV,
        "accepted transaction did not start")
    `MAX_ASSERT_IMP(a_one_side, i_clk, i_rst_n, o_in_ready, !o_out_valid,
        "ready and valid together")
    `MAX_ASSERT_NXT(a_load_to_out, i_clk, i_rst_n, o_cmd.out_load, r_state == ST_OUT,
        "result load without output")
endmodule
`default_nettype wire

/* hw/rtl/max_dp.sv */
// ---------------------------------------------------------------------------
// Motor axis controller datapath
// Holds axis state, runs calibration and speed selection, scales targets
// with a restoring divider one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "motor_axis_calibrate_and_drive_macros.svh"
module max_dp
    import max_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  wire                 i_cfg_fire,
    input  wire  [1:0]          i_cfg_idx,
    input  wire  [15:0]         i_cfg_data,
    input  wire  [3:0]          i_op,
    input  wire  [PosBits-1:0]  i_position,
    input  wire  [TimeBits-1:0] i_now,
    input  wire  signed [7:0]   i_pid,
    input  wire  [1:0]          i_mask,
    input  wire                 i_active,
    input  wire  [15:0]         i_treq,
    input  wire  signed [7:0]   i_sreq,
    output logic [51:0]         o_result
);
    localparam int DW = PosBits + 2;     // signed difference width
    localparam int PW = 2 * PosBits + 2; // product magnitude width

    logic [15:0] r_min_t, r_max_t, r_gap, r_hit;
    logic [3:0]  r_op;
    logic [PosBits-1:0] r_pos;
    logic [TimeBits-1:0] r_now;
    logic signed [7:0] r_pid, r_sreq;
    logic [1:0]  r_mask;
    logic        r_active;
    logic [15:0] r_treq;

    logic [2:0]  r_sw, n_sw;
    logic [3:0]  r_stage, n_stage;
    t_src        r_src, n_src;
    logic [1:0]  r_fault, n_fault;
    logic signed [7:0] r_speed, n_speed, r_cmd, n_cmd;
    logic [PosBits-1:0] r_tgt, n_tgt, r_smin, n_smin, r_smax, n_smax, r_saved, n_saved;
    logic [TimeBits-1:0] r_t0, n_t0;

    logic [PW-1:0] r_rem, r_quo;
    logic [DW-1:0] r_den;
    logic          r_neg;
    logic [CntBits-1:0] r_cnt;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_t <= 16'd0; r_max_t <= 16'hFFFF; r_gap <= 16'd500; r_hit <= 16'd0;
        end else if (i_cfg_fire) begin
            case (i_cfg_idx)
                RegMinT: r_min_t <= i_cfg_data;
                RegMaxT: r_max_t <= i_cfg_data;
                RegGap:  r_gap <= i_cfg_data;
                RegHit:  r_hit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // hold the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_op <= i_op; r_pos <= i_position; r_now <= i_now; r_pid <= i_pid;
            r_mask <= i_mask; r_active <= i_active; r_treq <= i_treq; r_sreq <= i_sreq;
        end
    end

    assign o_sts.is_target = (r_op == OP_TARGET) && (r_min_t != r_max_t);
    assign o_sts.div_last  = (r_cnt == CntBits'(PW));

    // divider operands from the live item (start) and state
    logic signed [DW-1:0] w_num_d, w_rng_d, w_den_d;
    logic signed [2*DW-1:0] w_prod;
    always_comb begin
        w_num_d = DW'($signed({2'b0, i_treq})) - DW'($signed({2'b0, r_min_t}));
        w_rng_d = DW'($signed({2'b0, r_smax})) - DW'($signed({2'b0, r_smin}));
        w_den_d = DW'($signed({2'b0, r_max_t})) - DW'($signed({2'b0, r_min_t}));
        w_prod  = w_num_d * w_rng_d;
    end

    // restoring divider, one bit per cycle
    logic [PW:0] w_trial;
    always_comb begin
        w_trial = {r_rem[PW-1:0], r_quo[PW-1]} - {{(PW+1-DW){1'b0}}, r_den};
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg <= w_prod[2*DW-1] ^ w_den_d[DW-1];
            r_quo <= PW'(w_prod[2*DW-1] ? -w_prod : w_prod);
            r_den <= w_den_d[DW-1] ? -w_den_d : w_den_d;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (!w_trial[PW]) begin
                r_rem <= w_trial[PW-1:0];
                r_quo <= {r_quo[PW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[PW-2:0], r_quo[PW-1]};
                r_quo <= {r_quo[PW-2:0], 1'b0};
            end
        end
    end

    // scaled target with clamp
    logic signed [PW+1:0] w_t;
    logic [PosBits-1:0] w_scaled;
    always_comb begin
        w_t = (r_neg ? -$signed({2'b0, r_quo}) : $signed({2'b0, r_quo}))
            + $signed((PW+2)'(r_smin));
        if (w_t < $signed((PW+2)'(r_smin))) w_scaled = r_smin;
        else if (w_t > $signed((PW+2)'(r_smax))) w_scaled = r_smax;
        else w_scaled = w_t[PosBits-1:0];
    end

    // item execution
    logic w_acc, w_pv, w_iclr;
    logic [PosBits-1:0] w_pos, w_pval;
    logic signed [7:0] w_drive;
    logic [PosBits:0] w_m;
    logic [TimeBits-1:0] w_el;
    logic signed [PosBits+1:0] w_p, w_h, w_tt;
    logic w_wait, w_tout;
    always_comb begin
        n_sw = r_sw; n_stage = r_stage; n_src = r_src; n_fault = r_fault;
        n_speed = r_speed; n_cmd = r_cmd; n_tgt = r_tgt; n_smin = r_smin;
        n_smax = r_smax; n_saved = r_saved; n_t0 = r_t0;
        w_acc = 1'b0; w_pv = 1'b0; w_iclr = 1'b0; w_pval = '0; w_drive = '0;
        w_pos = r_pos;
        w_el = r_now - r_t0;
        w_wait = w_el >= WaitDirMs;
        w_tout = w_el >= TimeoutMs;
        w_m = {1'b0, HomePos} + (PosBits+1)'(r_gap);
        w_p = (PosBits+2)'(r_pos);
        w_h = (PosBits+2)'(r_hit);
        w_tt = (PosBits+2)'(r_tgt);
        case (t_op'(r_op))
            OP_STEP: begin
                case (r_src)
                    SRC_SUSP: n_speed = '0;
                    SRC_CAL: begin
                        case (r_stage)
                            StgReq: begin
                                if (r_sw[0]) n_stage = StgBwdHit;
                                else begin
                                    n_speed = -CalSpeed; w_pos = BwdPreset;
                                    w_pv = 1'b1; w_pval = BwdPreset;
                                    n_saved = BwdPreset; n_smax = MaxPreset;
                                    n_stage = StgBwdDir; n_t0 = r_now;
                                end
                            end
                            StgBwdDir: if (w_wait) n_stage = StgBwdVer;
                            StgBwdVer: begin
                                if (r_saved > r_pos) n_stage = StgBwdLim;
                                else begin
                                    n_stage = StgAbort; n_fault = FaultDir;
                                    n_src = SRC_SUSP; n_speed = '0;
                                end
                            end
                            StgBwdLim: begin
                                if (w_tout) begin
                                    n_stage = StgAbort; n_fault = FaultTime;
                                    n_src = SRC_SUSP; n_speed = '0;
                                end
                                if (r_sw[0]) n_stage = StgBwdHit;
                            end
                            StgBwdHit: begin
                                n_t0 = r_now; n_speed = '0; n_stage = StgStop;
                            end
                            StgStop: begin
                                if (w_wait) begin
                                    w_pos = HomePos; w_pv = 1'b1; w_pval = HomePos;
                                    n_saved = HomePos;
                                    n_smin = w_m[PosBits] ? '1 : w_m[PosBits-1:0];
                                    n_stage = StgFwdDir; n_speed = CalSpeed; n_t0 = r_now;
                                end
                            end
                            StgFwdDir: if (w_wait) n_stage = StgFwdVer;
                            StgFwdVer: begin
                                if (r_saved < r_pos) n_stage = StgFwdLim;
                                else begin
                                    n_stage = StgAbort; n_fault = FaultDir;
                                    n_src = SRC_SUSP; n_speed = '0;
                                end
                            end
                            StgFwdLim: begin
                                if (w_tout) begin
                                    n_stage = StgAbort; n_fault = FaultTime;
                                    n_src = SRC_SUSP; n_speed = '0;
                                end
                            end
                            StgFwdHit: begin
                                n_smax = (r_pos > r_gap) ? r_pos - r_gap : '0;
                                n_speed = -CalSpeed;
                                n_tgt = PosBits'(({1'b0, n_smax} + {1'b0, r_smin}) >> 1);
                                n_stage = StgCentre;
                            end
                            StgCentre: begin
                                if (r_pos <= r_tgt) begin
                                    n_speed = '0; n_stage = StgDone; n_fault = FaultNone;
                                end
                            end
                            default: ;
                        endcase
                        if (n_stage == StgDone) begin
                            w_iclr = 1'b1; n_src = SRC_PIDS;
                        end
                    end
                    SRC_PIDS: n_speed = r_pid;
                    SRC_LIN: begin
                        if (w_tt > w_p + w_h) n_speed = LinSpeed;
                        else if (w_tt < w_p - w_h) n_speed = -LinSpeed;
                        else n_speed = '0;
                    end
                    SRC_CMD: n_speed = r_cmd;
                    default: ;
                endcase
                if ((r_sw[0] && n_speed < 0) || (r_sw[1] && n_speed > 0) ||
                    (n_smin > w_pos && n_speed < 0) || (n_smax < w_pos && n_speed > 0)) begin
                    n_speed = '0; w_iclr = 1'b1;
                end
                w_drive = r_sw[2] ? 8'sd0 : n_speed;
            end
            OP_LIMIT: begin
                n_sw = r_active ? (r_sw | {1'b0, r_mask}) : (r_sw & ~{1'b0, r_mask});
                if ((r_stage == StgBwdLim || r_stage == StgBwdDir) && r_mask == 2'd1
                    && r_active) n_stage = StgBwdHit;
                if ((r_stage == StgFwdLim || r_stage == StgFwdDir) && r_mask == 2'd2
                    && r_active) n_stage = StgFwdHit;
            end
            OP_TARGET: n_tgt = r_smin;
            OP_ROTATE: begin
                if (r_src != SRC_CAL) begin
                    n_src = SRC_CMD; n_cmd = r_sreq; w_acc = 1'b1;
                end
            end
            OP_STOP:   begin n_sw[2] = 1'b1; w_acc = 1'b1; end
            OP_RESUME: begin n_sw[2] = 1'b0; w_acc = 1'b1; end
            OP_CALIB: begin
                n_sw[2] = 1'b0; n_src = SRC_CAL; n_stage = StgReq; w_acc = 1'b1;
            end
            OP_SUSPEND: begin n_src = SRC_SUSP; w_acc = 1'b1; end
            OP_PID: begin
                if (r_stage == StgDone) begin
                    w_iclr = 1'b1; n_src = SRC_PIDS; w_acc = 1'b1;
                end
            end
            OP_LINEAR: begin
                if (r_stage == StgDone) begin n_src = SRC_LIN; w_acc = 1'b1; end
            end
            default: ;
        endcase
        if (i_cmd.div_done) n_tgt = w_scaled;
    end

    // commit state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= '0; r_stage <= StgNone; r_src <= SRC_SUSP; r_fault <= FaultNone;
            r_speed <= '0; r_cmd <= '0; r_tgt <= '0; r_smin <= '0; r_smax <= '1;
            r_saved <= '0; r_t0 <= '0;
        end else if (i_cmd.exec) begin
            r_sw <= n_sw; r_stage <= n_stage; r_src <= n_src; r_fault <= n_fault;
            r_speed <= n_speed; r_cmd <= n_cmd; r_tgt <= n_tgt; r_smin <= n_smin;
            r_smax <= n_smax; r_saved <= n_saved; r_t0 <= n_t0;
        end else if (i_cmd.div_done) begin
            r_tgt <= w_scaled;
        end
    end

    // capture result: target, iclr, fault, src, stage, pval, pv, acc, drive
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_result <= {n_tgt[15:0], w_iclr, n_fault, 3'(n_src), n_stage,
                w_pval[15:0], w_pv, w_acc, w_drive};
        end
    end

    `MAX_ASSERT_NXT(a_stage_range, i_clk, i_rst_n, 1'b1, r_stage <= StgAbort,
        "calibration stage out of range")
    `MAX_ASSERT_IMP(a_no_step_div, i_clk, i_rst_n, i_cmd.div_step, o_sts.is_target,
        "divider stepped on a non-target item")
    `MAX_ASSERT_NXT(a_done_pid, i_clk, i_rst_n,
        i_cmd.exec && r_op == OP_PID && r_stage == StgDone, r_src == SRC_PIDS,
        "pid selection lost")
endmodule
`default_nettype wire

/* hw/rtl/motor_axis_calibrate_and_drive.sv */
// Flow: an accepted item is held, then executed and its result captured, then offered;
// a set target with a non-empty scale instead runs the restoring divider to completion.
// Throughput: one item at a time; the next item is accepted once the result is taken.
// Reset: synchronous active low i_rst_n restores axis state, config and sequencer state.
`default_nettype none
// ---------------------------------------------------------------------------
// Motor axis calibrate and drive
// Top level joining the sequencer and the axis datapath.
// ---------------------------------------------------------------------------
module motor_axis_calibrate_and_drive
    import max_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // op[3:0]
    input  wire  [3:0]  s_axis_tuser,
    // position[15:0] now_ms[47:16] pid_output[55:48] event_mask[57:56]
    // event_active[58] target_request[74:59] speed_request[82:75] zero[87:83]
    input  wire  [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // drive_speed[7:0] accepted[8] preset_valid[9] preset_value[25:10]
    // stage_now[29:26] source_now[32:30] error_code[34:33] integrator_clear[35]
    // target_now[51:36] zero[55:52]
    output logic [55:0] m_axis_tdata,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);
    t_cmd w_cmd;
    t_sts w_sts;
    logic [51:0] w_res;

    assign o_cfg_ready = 1'b1;
    assign m_axis_tdata = {4'd0, w_res};

    max_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_fire(s_axis_tvalid && s_axis_tready),
        .i_out_fire(m_axis_tvalid && m_axis_tready),
        .i_sts(w_sts), .o_cmd(w_cmd),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid)
    );

    max_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts),
        .i_cfg_fire(i_cfg_valid), .i_cfg_idx(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_op(s_axis_tuser), .i_position(s_axis_tdata[15:0]),
        .i_now(s_axis_tdata[47:16]), .i_pid(s_axis_tdata[55:48]),
        .i_mask(s_axis_tdata[57:56]), .i_active(s_axis_tdata[58]),
        .i_treq(s_axis_tdata[74:59]), .i_sreq(s_axis_tdata[82:75]),
        .o_result(w_res)
    );
endmodule
`default_nettype wire
